// ----- design/presence_detector_with_baseline_defines.svh -----
`ifndef PRESENCE_DETECTOR_WITH_BASELINE_DEFINES_SVH
`define PRESENCE_DETECTOR_WITH_BASELINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PDB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdb assertion failed");

`endif

// ----- design/pdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pdb_pkg;

  localparam int DIST_W = 16;
  localparam int TOL_W  = 16;
  localparam int XCHK_W = 8;
  localparam int IR_W   = 4;
  localparam int OP_W   = 2;
  localparam int EV_W   = 3;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [OP_W-1:0] OP_CHECK     = 2'd0;
  localparam logic [OP_W-1:0] OP_CAL_EMPTY = 2'd1;
  localparam logic [OP_W-1:0] OP_CAL_LAST  = 2'd2;
  localparam logic [OP_W-1:0] OP_RESERVED  = 2'd3;

  localparam logic [EV_W-1:0] EV_NONE        = 3'd0;
  localparam logic [EV_W-1:0] EV_CONFIRMING  = 3'd1;
  localparam logic [EV_W-1:0] EV_NEW         = 3'd2;
  localparam logic [EV_W-1:0] EV_REMOVED     = 3'd3;
  localparam logic [EV_W-1:0] EV_LINK_FAIL   = 3'd4;
  localparam logic [EV_W-1:0] EV_REJECTED    = 3'd5;
  localparam logic [EV_W-1:0] EV_CALIBRATING = 3'd6;
  localparam logic [EV_W-1:0] EV_CALIBRATED  = 3'd7;

  localparam logic TGT_EMPTY = 1'b0;
  localparam logic TGT_LAST  = 1'b1;

  // register select is paddr[2]
  localparam logic REG_TOLERANCE    = 1'b0;
  localparam logic REG_EXTRA_CHECKS = 1'b1;

  localparam logic [TOL_W-1:0]  TOLERANCE_RST    = 16'd32;
  localparam logic [XCHK_W-1:0] EXTRA_CHECKS_RST = 8'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;
    logic [DIST_W-1:0] dist_c;
    logic [IR_W-1:0]   ir_hits;
    logic              link_ok;
  } pdb_item_t;

  typedef struct packed {
    logic [EV_W-1:0] event_res;
    logic            box_empty;
  } pdb_result_t;

  typedef struct packed {
    logic [TOL_W-1:0]  tolerance;
    logic [XCHK_W-1:0] extra_checks;
  } pdb_cfg_t;

endpackage

`default_nettype wire

// ----- design/pdb_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pdb_in_if;
  import pdb_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DIST_W-1:0] dist_a;
  logic [DIST_W-1:0] dist_b;
  logic [DIST_W-1:0] dist_c;
  logic [IR_W-1:0]   ir_hits;
  logic              link_ok;

  modport source (
    output valid, operation, dist_a, dist_b, dist_c, ir_hits, link_ok,
    input  ready
  );

  modport sink (
    input  valid, operation, dist_a, dist_b, dist_c, ir_hits, link_ok,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/pdb_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pdb_out_if;
  import pdb_pkg::*;

  logic            valid;
  logic            ready;
  logic [EV_W-1:0] event_res;
  logic            box_empty;

  modport source (
    output valid, event_res, box_empty,
    input  ready
  );

  modport sink (
    input  valid, event_res, box_empty,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/presence_detector_with_baseline.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "presence_detector_with_baseline_defines.svh"

// Mailbox presence detector: one beat in (operation, three distances, infrared
// hits, link flag) gives one beat out (event code, empty flag). The block takes
// one beat per clock unless a stalled sink backs up both registers. Each beat
// passes an input register, one pass of compare, confirm and
// calibration-average logic that also updates the detector state, and a
// result register that offers the result to the sink; while the sink stalls,
// the beat waits in the input register. A full result register with a stalled
// sink still lets one more beat enter the input register. Calibration averages
// 2**SAMPLE_LOG2 samples (0..6). Registers over APB: tolerance at 0x0,
// extra_checks at 0x4; write them only while the block is idle.
module presence_detector_with_baseline #(
  parameter int SAMPLE_LOG2 = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pdb_in_if.sink                             in_ch,
  pdb_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pdb_pkg::APB_AW-1:0]    paddr,
  input  wire logic [pdb_pkg::APB_DW-1:0]    pwdata,
  output logic      [pdb_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);
  import pdb_pkg::*;

  pdb_cfg_t    cfg_r;
  pdb_item_t   item_r;
  logic        s1_valid_r;
  pdb_result_t out_res_r;
  logic        out_valid_r;
  pdb_result_t core_res;
  logic        s1_adv;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance    <= TOLERANCE_RST;
      cfg_r.extra_checks <= EXTRA_CHECKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TOLERANCE:    cfg_r.tolerance    <= pwdata[TOL_W-1:0];
        REG_EXTRA_CHECKS: cfg_r.extra_checks <= pwdata[XCHK_W-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOLERANCE:    prdata = APB_DW'(cfg_r.tolerance);
      REG_EXTRA_CHECKS: prdata = APB_DW'(cfg_r.extra_checks);
      default:          prdata = '0;
    endcase
  end

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.operation <= in_ch.operation;
      item_r.dist_a    <= in_ch.dist_a;
      item_r.dist_b    <= in_ch.dist_b;
      item_r.dist_c    <= in_ch.dist_c;
      item_r.ir_hits   <= in_ch.ir_hits;
      item_r.link_ok   <= in_ch.link_ok;
    end
  end

  pdb_core #(
    .SAMPLE_LOG2 (SAMPLE_LOG2)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = out_res_r.event_res;
  assign out_ch.box_empty = out_res_r.box_empty;

  `PDB_ASSERT_SAME(a_no_overrun, out_valid_r && !out_ch.ready && s1_valid_r, !in_ch.ready)
  `PDB_ASSERT_NEXT(a_stage_fill, in_ch.valid && in_ch.ready, s1_valid_r)
  `PDB_ASSERT_SAME(a_removed_empty, out_valid_r && out_res_r.event_res == EV_REMOVED, out_res_r.box_empty)
  `PDB_ASSERT_SAME(a_new_full, out_valid_r && out_res_r.event_res == EV_NEW, !out_res_r.box_empty)

endmodule

`default_nettype wire

// ----- design/pdb_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pdb_core #(
  parameter int SAMPLE_LOG2 = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire pdb_pkg::pdb_item_t   item,
  input  wire pdb_pkg::pdb_cfg_t    cfg,
  output pdb_pkg::pdb_result_t      res
);
  import pdb_pkg::*;

  localparam int SUM_W = DIST_W + SAMPLE_LOG2;
  localparam int CNT_W = SAMPLE_LOG2 + 1;
  localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'((1 << SAMPLE_LOG2) - 1);

  logic              box_empty_r, box_empty_nxt;
  logic [DIST_W-1:0] empty_base_r [3];
  logic [DIST_W-1:0] empty_base_nxt [3];
  logic [DIST_W-1:0] last_base_r [3];
  logic [DIST_W-1:0] last_base_nxt [3];
  logic [SUM_W-1:0]  cal_sum_r [3];
  logic [SUM_W-1:0]  cal_sum_nxt [3];
  logic [SUM_W-1:0]  sum_new [3];
  logic [CNT_W-1:0]  cal_count_r, cal_count_nxt;
  logic [CNT_W-1:0]  cnt_base;
  logic              cal_target_r, cal_target_nxt;
  logic [XCHK_W-1:0] confirm_r, confirm_nxt;
  logic [DIST_W-1:0] dist_v [3];
  logic              below_empty, below_last;
  logic              ir_any;
  logic              conf_more;
  logic              tgt;
  logic              restart;
  logic [EV_W-1:0]   ev;

  function automatic logic dist_below(input logic [DIST_W-1:0] dv,
                                      input logic [TOL_W-1:0]  tol,
                                      input logic [DIST_W-1:0] base);
    logic [DIST_W:0] s;
    s = {1'b0, dv} + {1'b0, tol};
    return s < {1'b0, base};
  endfunction

  assign dist_v[0] = item.dist_a;
  assign dist_v[1] = item.dist_b;
  assign dist_v[2] = item.dist_c;
  assign ir_any  = |item.ir_hits;
  assign conf_more = confirm_r < cfg.extra_checks;
  assign tgt     = (item.operation == OP_CAL_EMPTY) ? TGT_EMPTY : TGT_LAST;
  assign restart = (cal_count_r != '0) && (cal_target_r != tgt);
  assign cnt_base = restart ? '0 : cal_count_r;

  always_comb begin
    below_empty = 1'b0;
    below_last  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      below_empty = below_empty | dist_below(dist_v[i], cfg.tolerance, empty_base_r[i]);
      below_last  = below_last  | dist_below(dist_v[i], cfg.tolerance, last_base_r[i]);
      sum_new[i]  = (restart ? '0 : cal_sum_r[i]) + SUM_W'(dist_v[i]);
    end
  end

  always_comb begin
    box_empty_nxt  = box_empty_r;
    empty_base_nxt = empty_base_r;
    last_base_nxt  = last_base_r;
    cal_sum_nxt    = cal_sum_r;
    cal_count_nxt  = cal_count_r;
    cal_target_nxt = cal_target_r;
    confirm_nxt    = confirm_r;
    ev             = EV_NONE;
    unique case (item.operation) inside
      OP_CHECK: begin
        for (int i = 0; i < 3; i++) cal_sum_nxt[i] = '0;
        cal_count_nxt = '0;
        if (box_empty_r) begin
          if (below_empty || ir_any) begin
            if (conf_more) begin
              confirm_nxt = confirm_r + XCHK_W'(1);
              ev          = EV_CONFIRMING;
            end else begin
              confirm_nxt = '0;
              if (item.link_ok) begin
                box_empty_nxt = 1'b0;
                ev            = EV_NEW;
              end else begin
                ev = EV_LINK_FAIL;
              end
            end
          end else begin
            confirm_nxt = '0;
          end
        end else if (!ir_any && !below_empty) begin
          confirm_nxt = '0;
          if (item.link_ok) begin
            box_empty_nxt = 1'b1;
            ev            = EV_REMOVED;
          end else begin
            ev = EV_LINK_FAIL;
          end
        end else if (below_last) begin
          if (conf_more) begin
            confirm_nxt = confirm_r + XCHK_W'(1);
            ev          = EV_CONFIRMING;
          end else begin
            confirm_nxt = '0;
            ev          = item.link_ok ? EV_NEW : EV_LINK_FAIL;
          end
        end else begin
          confirm_nxt = '0;
        end
      end
      OP_CAL_EMPTY, OP_CAL_LAST: begin
        confirm_nxt    = '0;
        cal_target_nxt = tgt;
        if (cnt_base == CAL_LAST) begin
          for (int i = 0; i < 3; i++) begin
            if (tgt == TGT_EMPTY) empty_base_nxt[i] = sum_new[i][SUM_W-1 -: DIST_W];
            else last_base_nxt[i] = sum_new[i][SUM_W-1 -: DIST_W];
            cal_sum_nxt[i] = '0;
          end
          if (tgt == TGT_EMPTY) box_empty_nxt = 1'b1;
          cal_count_nxt = '0;
          ev            = EV_CALIBRATED;
        end else begin
          cal_sum_nxt   = sum_new;
          cal_count_nxt = cnt_base + CNT_W'(1);
          ev            = EV_CALIBRATING;
        end
      end
      default: begin
        ev = EV_REJECTED;
      end
    endcase
  end

  assign res.event_res = ev;
  assign res.box_empty = box_empty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_empty_r  <= 1'b1;
      cal_count_r  <= '0;
      cal_target_r <= TGT_EMPTY;
      confirm_r    <= '0;
      for (int i = 0; i < 3; i++) begin
        empty_base_r[i] <= '0;
        last_base_r[i]  <= '0;
        cal_sum_r[i]    <= '0;
      end
    end else if (adv) begin
      box_empty_r  <= box_empty_nxt;
      cal_count_r  <= cal_count_nxt;
      cal_target_r <= cal_target_nxt;
      confirm_r    <= confirm_nxt;
      empty_base_r <= empty_base_nxt;
      last_base_r  <= last_base_nxt;
      cal_sum_r    <= cal_sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sim/presence_detector_with_baseline_test.sv -----
`timescale 1ns / 1ps

module presence_detector_with_baseline_test;
  import pdb_pkg::*;

  localparam int SAMPLE_LOG2 = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ROUNDS = 220;

  class presence_tracker;
    logic [TOL_W-1:0]  tol;
    logic [XCHK_W-1:0] xchk;
    bit                empty_flag;
    logic [DIST_W-1:0] empty_base [3];
    logic [DIST_W-1:0] last_base [3];
    logic [21:0]       cal_sum [3];
    logic [6:0]        cal_cnt;
    logic              cal_tgt;
    logic [7:0]        confirm_cnt;
    pdb_result_t       pending_events [$];
    int                mismatches;
    int                checked;
    int                seen [8];

    function new();
      tol = TOLERANCE_RST;
      xchk = EXTRA_CHECKS_RST;
      empty_flag = 1'b1;
      for (int i = 0; i < 3; i++) begin
        empty_base[i] = '0;
        last_base[i] = '0;
      end
      drop_partial();
      cal_tgt = TGT_EMPTY;
      confirm_cnt = '0;
      mismatches = 0;
      checked = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void drop_partial();
      for (int i = 0; i < 3; i++) cal_sum[i] = '0;
      cal_cnt = '0;
    endfunction

    function bit below_any(input logic [DIST_W-1:0] d [3],
                           input logic [DIST_W-1:0] base [3]);
      for (int i = 0; i < 3; i++) begin
        if (({1'b0, d[i]} + {1'b0, tol}) < {1'b0, base[i]}) return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [EV_W-1:0] confirm_step(bit link, bit fills);
      if (confirm_cnt < xchk) begin
        confirm_cnt = confirm_cnt + 8'd1;
        return EV_CONFIRMING;
      end
      confirm_cnt = '0;
      if (!link) return EV_LINK_FAIL;
      if (fills) empty_flag = 1'b0;
      return EV_NEW;
    endfunction

    function void note_beat(pdb_item_t it);
      logic [DIST_W-1:0] d [3];
      bit                ir;
      bit                link;
      logic [EV_W-1:0]   ev;
      logic              tgt;
      pdb_result_t       r;
      d[0] = it.dist_a;
      d[1] = it.dist_b;
      d[2] = it.dist_c;
      ir = |it.ir_hits;
      link = it.link_ok;
      case (it.operation) inside
        OP_CHECK: begin
          drop_partial();
          if (empty_flag) begin
            if (below_any(d, empty_base) || ir) begin
              ev = confirm_step(link, 1'b1);
            end else begin
              confirm_cnt = '0;
              ev = EV_NONE;
            end
          end else if (!ir && !below_any(d, empty_base)) begin
            confirm_cnt = '0;
            if (link) begin
              empty_flag = 1'b1;
              ev = EV_REMOVED;
            end else begin
              ev = EV_LINK_FAIL;
            end
          end else if (below_any(d, last_base)) begin
            ev = confirm_step(link, 1'b0);
          end else begin
            confirm_cnt = '0;
            ev = EV_NONE;
          end
        end
        OP_CAL_EMPTY, OP_CAL_LAST: begin
          tgt = (it.operation == OP_CAL_EMPTY) ? TGT_EMPTY : TGT_LAST;
          confirm_cnt = '0;
          if (cal_cnt != 0 && cal_tgt != tgt) drop_partial();
          cal_tgt = tgt;
          for (int i = 0; i < 3; i++) cal_sum[i] = cal_sum[i] + 22'(d[i]);
          cal_cnt = cal_cnt + 7'd1;
          if (cal_cnt >= 7'(1 << SAMPLE_LOG2)) begin
            for (int i = 0; i < 3; i++) begin
              if (tgt == TGT_EMPTY) empty_base[i] = 16'(cal_sum[i] >> SAMPLE_LOG2);
              else last_base[i] = 16'(cal_sum[i] >> SAMPLE_LOG2);
            end
            if (tgt == TGT_EMPTY) empty_flag = 1'b1;
            drop_partial();
            ev = EV_CALIBRATED;
          end else begin
            ev = EV_CALIBRATING;
          end
        end
        default: ev = EV_REJECTED;
      endcase
      seen[ev]++;
      r.event_res = ev;
      r.box_empty = empty_flag;
      pending_events.push_back(r);
    endfunction

    function void check_beat(pdb_result_t got);
      pdb_result_t want;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat event=%0d empty=%0d",
                   $realtime, got.event_res, got.box_empty);
        return;
      end
      want = pending_events.pop_front();
      checked++;
      if (got.event_res !== want.event_res || got.box_empty !== want.box_empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d mismatch: event exp %0d got %0d, empty exp %0d got %0d",
                   $realtime, checked, want.event_res, got.event_res,
                   want.box_empty, got.box_empty);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  pdb_in_if  in_ch ();
  pdb_out_if out_ch ();

  presence_detector_with_baseline #(.SAMPLE_LOG2(SAMPLE_LOG2)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  presence_tracker tracker = new();

  int cycle_count = 0;
  int rounds_sent = 0;
  int sink_hold = 0;
  bit calm = 1'b0;
  int empty_center [3];
  int last_center [3];

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [DIST_W-1:0] clamp16(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return DIST_W'(v);
  endfunction

  function automatic pdb_item_t make_item(logic [OP_W-1:0] op, logic [DIST_W-1:0] a,
                                          logic [DIST_W-1:0] b, logic [DIST_W-1:0] c,
                                          logic [IR_W-1:0] ir, logic link);
    pdb_item_t it;
    it.operation = op;
    it.dist_a = a;
    it.dist_b = b;
    it.dist_c = c;
    it.ir_hits = ir;
    it.link_ok = link;
    return it;
  endfunction

  // aim near the tolerance edge of a baseline, or quiet, or clearly closer, or anywhere at random
  function automatic logic [DIST_W-1:0] pick_dist(int center);
    int tol_i;
    int jit;
    tol_i = int'(tracker.tol);
    jit = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 9)) inside
      [0:3]:   return clamp16(center - tol_i + jit);
      [4:6]:   return clamp16(center + int'($urandom_range(0, 40)));
      7:       return clamp16(int'($urandom_range(0, center)));
      default: return DIST_W'($urandom);
    endcase
  endfunction

  task automatic send_item(pdb_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.operation;
    in_ch.dist_a    <= it.dist_a;
    in_ch.dist_b    <= it.dist_b;
    in_ch.dist_c    <= it.dist_c;
    in_ch.ir_hits   <= it.ir_hits;
    in_ch.link_ok   <= it.link_ok;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_beat(it);
    if (it.operation != OP_RESERVED) rounds_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int tol, int xchk);
    reg_write({REG_TOLERANCE, 2'b00}, APB_DW'(tol));
    tracker.tol = TOL_W'(tol);
    reg_write({REG_EXTRA_CHECKS, 2'b00}, APB_DW'(xchk));
    tracker.xchk = XCHK_W'(xchk);
  endtask

  task automatic run_directed();
    send_item(make_item(OP_RESERVED, '1, '1, '1, '1, 1'b1));
    send_item(make_item(OP_CHECK, '0, '0, '0, '0, 1'b1));
    // partial last-content set, then switch to the empty set
    send_item(make_item(OP_CAL_LAST, 16'h1234, 16'h0100, 16'hFFFF, '0, 1'b1));
    send_item(make_item(OP_CAL_LAST, 16'h1234, 16'h0100, 16'hFFFF, '0, 1'b1));
    repeat (1 << SAMPLE_LOG2)
      send_item(make_item(OP_CAL_EMPTY, 16'hFFFF, 16'h0800, 16'h0000, 4'hF, 1'b0));
    empty_center = '{65535, 2048, 0};
    send_item(make_item(OP_CHECK, 16'hFFFF, 16'h07DF, 16'h0000, '0, 1'b1));
    send_item(make_item(OP_CHECK, 16'hFFFF, 16'h07E0, 16'h0000, '0, 1'b1));
    send_item(make_item(OP_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h1, 1'b1));
    send_item(make_item(OP_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h2, 1'b1));
    send_item(make_item(OP_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h8, 1'b0));
    repeat (3) send_item(make_item(OP_CHECK, 16'h0000, 16'hFFFF, 16'hFFFF, '0, 1'b1));
    send_item(make_item(OP_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, 1'b0));
    send_item(make_item(OP_CHECK, 16'h0000, 16'hFFFF, 16'hFFFF, '0, 1'b1));
    send_item(make_item(OP_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, 1'b1));
    send_item(make_item(OP_CAL_LAST, 16'h0400, 16'h0400, 16'h0400, '0, 1'b0));
    send_item(make_item(OP_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, 1'b1));
  endtask

  task automatic run_episode();
    int        kind;
    int        n;
    int        stop;
    int        ctr [3];
    logic      to_last;
    pdb_item_t it;
    kind = $urandom_range(0, 9);
    calm = ($urandom_range(0, 5) == 0);
    if (kind < 2) begin
      to_last = 1'($urandom_range(0, 1));
      for (int k = 0; k < 3; k++) ctr[k] = $urandom_range(0, 65535);
      n = 1 << SAMPLE_LOG2;
      stop = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : n;
      for (int s = 0; s < stop; s++) begin
        it = make_item(to_last ? OP_CAL_LAST : OP_CAL_EMPTY,
                       clamp16(ctr[0] + int'($urandom_range(0, 30)) - 15),
                       clamp16(ctr[1] + int'($urandom_range(0, 30)) - 15),
                       clamp16(ctr[2] + int'($urandom_range(0, 30)) - 15),
                       IR_W'($urandom), 1'($urandom));
        send_item(it);
      end
      if (stop == n) begin
        if (to_last) last_center = ctr;
        else empty_center = ctr;
      end
    end else if (kind < 8) begin
      n = $urandom_range(4, 20);
      repeat (n) begin
        it.operation = OP_CHECK;
        it.dist_a = pick_dist(($urandom_range(0, 2) == 0) ? last_center[0] : empty_center[0]);
        it.dist_b = pick_dist(($urandom_range(0, 2) == 0) ? last_center[1] : empty_center[1]);
        it.dist_c = pick_dist(($urandom_range(0, 2) == 0) ? last_center[2] : empty_center[2]);
        it.ir_hits = ($urandom_range(0, 6) == 0) ? IR_W'($urandom_range(1, 15)) : '0;
        it.link_ok = ($urandom_range(0, 9) != 0);
        send_item(it);
      end
    end else begin
      repeat ($urandom_range(1, 3))
        send_item(make_item(OP_W'($urandom_range(0, 3)), DIST_W'($urandom),
                            DIST_W'($urandom), DIST_W'($urandom),
                            IR_W'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    pdb_result_t got;
    int          stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.event_res = out_ch.event_res;
      got.box_empty = out_ch.box_empty;
      tracker.check_beat(got);
    end
  end

  initial begin
    int tol_set [PHASES];
    int xchk_set [PHASES];
    int start;
    tol_set  = '{32, 0, 65535, 16, 200, 0};
    xchk_set = '{2, 0, 255, 1, 4, 0};
    tol_set[PHASES-1]  = $urandom_range(0, 300);
    xchk_set[PHASES-1] = $urandom_range(0, 6);
    last_center = '{0, 0, 0};
    empty_center = '{0, 0, 0};
    rst_n     <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_CHECK;
    in_ch.dist_a    <= '0;
    in_ch.dist_b    <= '0;
    in_ch.dist_c    <= '0;
    in_ch.ir_hits   <= '0;
    in_ch.link_ok   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p > 0) set_config(tol_set[p], xchk_set[p]);
      if (p == 1) begin
        // stall the sink long enough to back up the pipeline
        calm = 1'b1;
        sink_hold = 150;
        repeat (30) send_item(make_item(OP_CHECK, DIST_W'($urandom), DIST_W'($urandom),
                                        DIST_W'($urandom), '0, 1'b1));
      end
      start = rounds_sent;
      while (rounds_sent - start < PHASE_ROUNDS) run_episode();
    end
    calm = 1'b0;
    wait_drained();

    $display("Covered %0d sensor rounds over %0d register settings, %0d results checked.",
             rounds_sent, PHASES, tracker.checked);
    $display("Events: %0d new, %0d removed, %0d link failures, %0d calibrations, %0d mismatches.",
             tracker.seen[EV_NEW], tracker.seen[EV_REMOVED], tracker.seen[EV_LINK_FAIL],
             tracker.seen[EV_CALIBRATED], tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
